### src/escaped_frame_deframer_core_defines.svh
// assertion macros for the escaped frame deframer
`ifndef ESCAPED_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define ESCAPED_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, checked at each rising clock edge out of reset
`define EFD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at each rising clock edge out of reset
`define EFD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/efd_pkg.sv
// shared types and constants of the escaped frame deframer
package efd_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;

   localparam logic [1:0] REG_SEPARATOR = 2'd0;
   localparam logic [1:0] REG_ESCAPE    = 2'd1;
   localparam logic [1:0] REG_MAX_OUT   = 2'd2;

   localparam logic [BYTE_W-1:0] SEPARATOR_RESET = 8'd126;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET    = 8'd125;
   localparam logic [LEN_W-1:0]  MAX_OUT_RESET   = 7'd64;

   typedef struct packed {
      logic              is_end;
      logic [BYTE_W-1:0] data;
   } efd_cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_byte;
      logic              frame_last;
      logic              frame_empty;
      logic [LEN_W-1:0]  frame_length;
   } efd_result_type;

endpackage

### src/efd_front.sv
// front part: escape handling and classification of received bytes
module efd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [efd_pkg::BYTE_W-1:0]     rx_byte,
   output logic                           full,
   input  logic [efd_pkg::BYTE_W-1:0]     separator_byte,
   input  logic [efd_pkg::BYTE_W-1:0]     escape_byte,
   output logic                           q_push,
   output efd_pkg::efd_cmd_type           q_cmd,
   input  logic                           q_full
);

   logic escape_pending_ff;
   logic escape_pending_in;
   logic accept;
   logic is_sep;
   logic is_esc;

   assign full   = q_full;
   assign accept = push && !q_full;
   assign is_sep = !escape_pending_ff && (rx_byte == separator_byte);
   assign is_esc = !escape_pending_ff && (rx_byte == escape_byte);

   always_comb begin
      escape_pending_in = escape_pending_ff;
      q_push            = 1'b0;
      q_cmd.is_end      = is_sep;
      q_cmd.data        = rx_byte;
      if (accept) begin
         if (is_sep) begin
            q_push            = 1'b1;
            escape_pending_in = 1'b0;
         end else if (is_esc) begin
            escape_pending_in = 1'b1;
         end else begin
            q_push            = 1'b1;
            escape_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
      end else begin
         escape_pending_ff <= escape_pending_in;
      end
   end

endmodule

### src/efd_queue.sv
// short command queue between front and back
module efd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  efd_pkg::efd_cmd_type din,
   output logic                 full,
   input  logic                 pop,
   output efd_pkg::efd_cmd_type dout,
   output logic                 empty
);

   localparam int QAW = (efd_pkg::QUEUE_DEPTH > 1) ? $clog2(efd_pkg::QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(efd_pkg::QUEUE_DEPTH + 1);

   efd_pkg::efd_cmd_type entry_ff [efd_pkg::QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff;
   logic [QAW-1:0] wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff;
   logic [QAW-1:0] rd_ptr_in;
   logic [QCW-1:0] count_ff;
   logic [QCW-1:0] count_in;
   logic           do_push;
   logic           do_pop;

   assign full    = (count_ff == QCW'(efd_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(efd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(efd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### src/efd_back.sv
// back part: frame store, clipping and result delivery
module efd_back #(
   parameter int FRAME_BYTES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [efd_pkg::LEN_W-1:0]     max_frame_out,
   input  efd_pkg::efd_cmd_type          q_cmd,
   input  logic                          q_empty,
   output logic                          q_pop,
   output efd_pkg::efd_result_type       result,
   output logic                          result_valid,
   input  logic                          result_pop
);

   localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int CW = $clog2(FRAME_BYTES + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_LOAD  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   logic [efd_pkg::BYTE_W-1:0] mem [FRAME_BYTES];

   logic [1:0]                  state_ff;
   logic [1:0]                  state_in;
   logic [CW-1:0]               count_ff;
   logic [CW-1:0]               count_in;
   logic [CW-1:0]               count_base;
   logic [AW-1:0]               idx_ff;
   logic [AW-1:0]               idx_in;
   logic [efd_pkg::LEN_W-1:0]   len_ff;
   logic [efd_pkg::LEN_W-1:0]   len_in;
   logic [efd_pkg::LEN_W-1:0]   len_calc;
   logic [efd_pkg::LEN_W-1:0]   count_wide;
   logic [efd_pkg::BYTE_W-1:0]  rdata_ff;
   efd_pkg::efd_result_type     out_ff;
   efd_pkg::efd_result_type     out_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic                        out_free;
   logic                        is_last;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic                        rd_en;

   assign count_base   = (count_ff == CW'(FRAME_BYTES)) ? '0 : count_ff;
   assign count_wide   = efd_pkg::LEN_W'(count_ff);
   assign len_calc     = (count_wide < max_frame_out) ? count_wide : max_frame_out;
   assign out_free     = !out_valid_ff || result_pop;
   assign is_last      = ((efd_pkg::LEN_W'(idx_ff) + 7'd1) == len_ff);
   assign result       = out_ff;
   assign result_valid = out_valid_ff;
   assign rd_en        = (state_ff == ST_READ);
   assign wr_addr      = count_base[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !result_pop;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_cmd.is_end) begin
                  len_in   = len_calc;
                  idx_in   = '0;
                  count_in = '0;
                  state_in = (len_calc == '0) ? ST_EMPTY : ST_READ;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_base + 1'b1;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (out_free) begin
               out_in.frame_byte   = rdata_ff;
               out_in.frame_last   = is_last;
               out_in.frame_empty  = 1'b0;
               out_in.frame_length = len_ff;
               out_valid_in        = 1'b1;
               idx_in              = idx_ff + 1'b1;
               state_in            = is_last ? ST_IDLE : ST_READ;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               out_in.frame_byte   = '0;
               out_in.frame_last   = 1'b1;
               out_in.frame_empty  = 1'b1;
               out_in.frame_length = '0;
               out_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= q_cmd.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[idx_ff];
      end
   end

endmodule

### src/escaped_frame_deframer_core.sv
// top level of the escaped frame deframer: control registers and channel wiring
//
// usage
//   req_ channel: raw received bytes, one beat per push while req_full is low.
//   rsp_ channel: unstuffed frame bytes; a frame ends with rsp_frame_last, and an
//   empty frame gives a single beat with rsp_frame_empty set.
//   csr_ port: separator byte at 0x0, escape byte at 0x4, max frame length at 0x8.
// timing
//   a byte is accepted and passes through a two-entry command queue
//   to the frame store; while the back end is idle one byte is taken per cycle.
//   after the separator the first beat passes READ (registered store read) and
//   LOAD, an empty frame EMPTY; each further beat again passes READ and LOAD.
//   while a frame is delivered the queue fills and req_full rises after two beats.
// reset
//   synchronous; clears queue, counts, escape state and the output valid flag and
//   loads the control registers with separator 126, escape 125 and length 64.
// stall
//   a held rsp_ beat stays on the ports; the back end waits and the queue backs
//   up into req_full, with no beat lost.
`include "escaped_frame_deframer_core_defines.svh"

module escaped_frame_deframer_core #(
   parameter int FRAME_BYTES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic [efd_pkg::BYTE_W-1:0]        req_rx_byte,
   output logic                              req_full,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [efd_pkg::BYTE_W-1:0]        rsp_frame_byte,
   output logic                              rsp_frame_last,
   output logic                              rsp_frame_empty,
   output logic [efd_pkg::LEN_W-1:0]         rsp_frame_length,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [efd_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [efd_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [efd_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);

   logic [efd_pkg::BYTE_W-1:0] separator_ff;
   logic [efd_pkg::BYTE_W-1:0] escape_ff;
   logic [efd_pkg::LEN_W-1:0]  max_out_ff;
   logic [1:0]                 csr_index;
   logic                       csr_write;

   efd_pkg::efd_cmd_type       f_cmd;
   efd_pkg::efd_cmd_type       q_cmd;
   logic                       f_push;
   logic                       q_full;
   logic                       q_empty;
   logic                       q_pop;
   efd_pkg::efd_result_type    result;
   logic                       result_valid;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         separator_ff <= efd_pkg::SEPARATOR_RESET;
         escape_ff    <= efd_pkg::ESCAPE_RESET;
         max_out_ff   <= efd_pkg::MAX_OUT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            efd_pkg::REG_SEPARATOR: separator_ff <= csr_pwdata[efd_pkg::BYTE_W-1:0];
            efd_pkg::REG_ESCAPE:    escape_ff    <= csr_pwdata[efd_pkg::BYTE_W-1:0];
            efd_pkg::REG_MAX_OUT:   max_out_ff   <= csr_pwdata[efd_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         efd_pkg::REG_SEPARATOR: csr_prdata = efd_pkg::CSR_DW'(separator_ff);
         efd_pkg::REG_ESCAPE:    csr_prdata = efd_pkg::CSR_DW'(escape_ff);
         efd_pkg::REG_MAX_OUT:   csr_prdata = efd_pkg::CSR_DW'(max_out_ff);
         default:                csr_prdata = '0;
      endcase
   end

   efd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (req_push),
      .rx_byte        (req_rx_byte),
      .full           (req_full),
      .separator_byte (separator_ff),
      .escape_byte    (escape_ff),
      .q_push         (f_push),
      .q_cmd          (f_cmd),
      .q_full         (q_full)
   );

   efd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_push),
      .din   (f_cmd),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_cmd),
      .empty (q_empty)
   );

   efd_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .max_frame_out (max_out_ff),
      .q_cmd         (q_cmd),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .result        (result),
      .result_valid  (result_valid),
      .result_pop    (rsp_pop)
   );

   assign rsp_empty        = !result_valid;
   assign rsp_frame_byte   = result.frame_byte;
   assign rsp_frame_last   = result.frame_last;
   assign rsp_frame_empty  = result.frame_empty;
   assign rsp_frame_length = result.frame_length;

   `EFD_ASSERT_NOW(a_queue_no_overflow, f_push, !q_full, "command queue overflow")
   `EFD_ASSERT_NOW(a_empty_frame_shape, !rsp_empty && rsp_frame_empty,
      rsp_frame_last && (rsp_frame_length == 7'd0), "empty frame beat malformed")
   `EFD_ASSERT_NOW(a_length_bound, !rsp_empty && !rsp_frame_empty,
      (rsp_frame_length != 7'd0) && (rsp_frame_length <= efd_pkg::LEN_W'(FRAME_BYTES)),
      "frame length out of range")
   `EFD_ASSERT_NEXT(a_pop_only_when_queued, q_pop, !$past(q_empty), "queue popped while empty")

endmodule
